### sv/etsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the expression token syntax checker.
// Used by every module of the block; depends on nothing.
package etsc_pkg;

    // Deepest nesting that each of the two counters may reach.
    localparam int MAX_NEST = 255;
    localparam int CNT_W    = $clog2(MAX_NEST + 1);
    localparam int DEPTH_W  = 9;
    localparam int SUM_W    = (CNT_W + 1 > DEPTH_W) ? CNT_W + 1 : DEPTH_W;

    // Entries of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token classes.
    localparam logic [3:0] KIND_START  = 4'd0;
    localparam logic [3:0] KIND_LPAREN = 4'd1;
    localparam logic [3:0] KIND_LBRACK = 4'd2;
    localparam logic [3:0] KIND_CALL   = 4'd3;
    localparam logic [3:0] KIND_VALUE  = 4'd4;
    localparam logic [3:0] KIND_NOT    = 4'd5;
    localparam logic [3:0] KIND_RPAREN = 4'd6;
    localparam logic [3:0] KIND_RBRACK = 4'd7;
    localparam logic [3:0] KIND_BINARY = 4'd8;

    // Expression roles.
    localparam logic [2:0] ROLE_VALUE = 3'd1;
    localparam logic [2:0] ROLE_BINOP = 3'd2;
    localparam logic [2:0] ROLE_UNIOP = 3'd3;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_OPERAND    = 3'd1,
        STATUS_OPERATOR   = 3'd2,
        STATUS_UNMATCHED  = 3'd3,
        STATUS_UNKNOWN    = 3'd4
    } status_t;

    // What a token does to the nesting counters.
    typedef enum logic [2:0] {
        CNT_NONE,
        CNT_LPAREN,
        CNT_LBRACK,
        CNT_RPAREN,
        CNT_RBRACK
    } cnt_op_t;

    // Which neighbor test a token must pass.
    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_OPERAND,
        CHK_UNARY,
        CHK_BINARY,
        CHK_UNKNOWN
    } chk_op_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] token_type;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        status_t            status;
        logic               done_res;
    } out_item_t;

    // Classified token handed from front to back.
    typedef struct packed {
        cnt_op_t cnt_op;
        chk_op_t chk_op;
        logic    opnd_after;  // an operand may follow this token
        logic    oper_after;  // a binary operator may follow this token
        logic    last;
    } tok_t;

endpackage

### sv/expression_token_syntax_checker.sv
`timescale 1ns / 1ps
// Expression token syntax checker, top level.
// Instantiates etsc_front, etsc_queue and etsc_back; depends on etsc_pkg.
//
// Usage:
//   Tokens enter on the s_ channel (valid/ready), one request per token, with
//   kind, token_type and last. Each token gives exactly one result on the m_
//   channel: the nesting depth before the token, the sticky status so far and
//   done_res, which is set on the result of the last token of an expression.
//   The status on that result is final and the checker then starts afresh.
//
//   A token accepted on the s_ channel is written into the queue, then into the
//   output register, and only then can it be taken at the m_ port. Throughput:
//   one token per cycle while the receiver takes results; a stall holds the flow.
//   A two-entry queue sits between the classifying front end and the back end;
//   the back end writes into an output register and keeps accepting from the
//   queue whenever that register is empty or being taken in the same cycle.
//   When the receiver stalls, the output register holds, the queue fills and
//   s_ready drops once it is full; nothing is lost.
//   Reset (aresetn low, synchronous) empties the queue and output register and
//   returns the checker to the start-of-expression state.
module expression_token_syntax_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  etsc_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output etsc_pkg::out_item_t  m_data
);

    etsc_pkg::tok_t front_tok;
    etsc_pkg::tok_t q_data;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           push;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    etsc_front u_front (
        .in_item (s_data),
        .tok     (front_tok)
    );

    etsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_tok),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    etsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### sv/etsc_front.sv
`timescale 1ns / 1ps
// Front end: decodes a raw token into counter action, check and follow rules.
// Depends on etsc_pkg.
module etsc_front (
    input  etsc_pkg::in_item_t in_item,
    output etsc_pkg::tok_t     tok
);

    logic [3:0] kind;
    logic [2:0] role;

    assign kind = in_item.kind;
    assign role = in_item.token_type;

    always_comb begin
        tok.cnt_op = etsc_pkg::CNT_NONE;
        tok.chk_op = etsc_pkg::CHK_OPERAND;
        case (kind)
            etsc_pkg::KIND_START: begin
                tok.chk_op = etsc_pkg::CHK_NONE;
            end
            etsc_pkg::KIND_LPAREN: begin
                tok.cnt_op = etsc_pkg::CNT_LPAREN;
            end
            etsc_pkg::KIND_LBRACK, etsc_pkg::KIND_CALL: begin
                if (kind == etsc_pkg::KIND_LBRACK) begin
                    tok.cnt_op = etsc_pkg::CNT_LBRACK;
                end
                // Role decides whether a bracket or call acts as an operator.
                if (role == etsc_pkg::ROLE_BINOP) begin
                    tok.chk_op = etsc_pkg::CHK_BINARY;
                end else if (role == etsc_pkg::ROLE_UNIOP) begin
                    tok.chk_op = etsc_pkg::CHK_UNARY;
                end
            end
            etsc_pkg::KIND_VALUE: begin
                tok.chk_op = etsc_pkg::CHK_OPERAND;
            end
            etsc_pkg::KIND_NOT: begin
                tok.chk_op = etsc_pkg::CHK_UNARY;
            end
            etsc_pkg::KIND_RPAREN: begin
                tok.cnt_op = etsc_pkg::CNT_RPAREN;
                tok.chk_op = etsc_pkg::CHK_BINARY;
            end
            etsc_pkg::KIND_RBRACK: begin
                tok.cnt_op = etsc_pkg::CNT_RBRACK;
                tok.chk_op = etsc_pkg::CHK_BINARY;
            end
            etsc_pkg::KIND_BINARY: begin
                tok.chk_op = etsc_pkg::CHK_BINARY;
            end
            default: begin
                tok.chk_op = etsc_pkg::CHK_UNKNOWN;
            end
        endcase

        tok.opnd_after = (role == etsc_pkg::ROLE_BINOP) || (role == etsc_pkg::ROLE_UNIOP)
                      || (kind == etsc_pkg::KIND_LBRACK) || (kind == etsc_pkg::KIND_LPAREN)
                      || (kind == etsc_pkg::KIND_START);
        tok.oper_after = (role == etsc_pkg::ROLE_VALUE) || (kind == etsc_pkg::KIND_RBRACK)
                      || (kind == etsc_pkg::KIND_RPAREN);
        tok.last       = in_item.last;
    end

endmodule

### sv/etsc_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of classified tokens between front and back.
// Depends on etsc_pkg.
module etsc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  etsc_pkg::tok_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output etsc_pkg::tok_t  q_data
);

    etsc_pkg::tok_t              mem_reg [etsc_pkg::QUEUE_DEPTH];
    logic [etsc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [etsc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [etsc_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic [etsc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [etsc_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == etsc_pkg::QPTR_W'(etsc_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + etsc_pkg::QPTR_W'(1);
    endfunction

    assign full    = (count_reg == etsc_pkg::QCNT_W'(etsc_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + etsc_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - etsc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/etsc_back.sv
`timescale 1ns / 1ps
// Back end: nesting counters, sticky error and the registered result stage.
// Depends on etsc_pkg.
module etsc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  etsc_pkg::tok_t       q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output etsc_pkg::out_item_t  m_data
);

    logic [etsc_pkg::CNT_W-1:0] paren_reg, paren_next;
    logic [etsc_pkg::CNT_W-1:0] bracket_reg, bracket_next;
    logic [etsc_pkg::CNT_W-1:0] saved_reg, saved_next;
    etsc_pkg::status_t          error_reg, error_next;
    logic                       opnd_ok_reg, opnd_ok_next;
    logic                       oper_ok_reg, oper_ok_next;
    logic                       m_valid_reg, m_valid_next;
    etsc_pkg::out_item_t        m_data_reg, m_data_next;

    logic [etsc_pkg::SUM_W-1:0] depth_sum;
    logic                       cnt_fail;
    etsc_pkg::status_t          tok_status;
    etsc_pkg::status_t          status_now;
    logic [etsc_pkg::CNT_W-1:0] paren_upd, bracket_upd, saved_upd;

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign depth_sum = etsc_pkg::SUM_W'(paren_reg) + etsc_pkg::SUM_W'(bracket_reg);

    // Counter action of the token at the head of the queue.
    always_comb begin
        cnt_fail    = 1'b0;
        paren_upd   = paren_reg;
        bracket_upd = bracket_reg;
        saved_upd   = saved_reg;
        case (q_data.cnt_op)
            etsc_pkg::CNT_LPAREN: begin
                cnt_fail  = (paren_reg >= etsc_pkg::CNT_W'(etsc_pkg::MAX_NEST));
                paren_upd = paren_reg + etsc_pkg::CNT_W'(1);
                saved_upd = bracket_reg;
            end
            etsc_pkg::CNT_LBRACK: begin
                cnt_fail    = (bracket_reg >= etsc_pkg::CNT_W'(etsc_pkg::MAX_NEST));
                bracket_upd = bracket_reg + etsc_pkg::CNT_W'(1);
            end
            etsc_pkg::CNT_RPAREN: begin
                cnt_fail  = (paren_reg == '0) || (bracket_reg > saved_reg);
                paren_upd = paren_reg - etsc_pkg::CNT_W'(1);
            end
            etsc_pkg::CNT_RBRACK: begin
                cnt_fail    = (bracket_reg == '0);
                bracket_upd = bracket_reg - etsc_pkg::CNT_W'(1);
            end
            default: begin
                cnt_fail = 1'b0;
            end
        endcase
    end

    // Neighbor test against the previous accepted token.
    always_comb begin
        case (q_data.chk_op)
            etsc_pkg::CHK_NONE: begin
                tok_status = etsc_pkg::STATUS_OK;
            end
            etsc_pkg::CHK_OPERAND: begin
                tok_status = opnd_ok_reg ? etsc_pkg::STATUS_OK : etsc_pkg::STATUS_OPERAND;
            end
            etsc_pkg::CHK_UNARY: begin
                tok_status = opnd_ok_reg ? etsc_pkg::STATUS_OK : etsc_pkg::STATUS_OPERATOR;
            end
            etsc_pkg::CHK_BINARY: begin
                tok_status = oper_ok_reg ? etsc_pkg::STATUS_OK : etsc_pkg::STATUS_OPERATOR;
            end
            default: begin
                tok_status = etsc_pkg::STATUS_UNKNOWN;
            end
        endcase
        if (cnt_fail) begin
            tok_status = etsc_pkg::STATUS_UNMATCHED;
        end
    end

    always_comb begin
        paren_next   = paren_reg;
        bracket_next = bracket_reg;
        saved_next   = saved_reg;
        error_next   = error_reg;
        opnd_ok_next = opnd_ok_reg;
        oper_ok_next = oper_ok_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        status_now   = error_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (q_pop) begin
            // Once an error is held, the state stays frozen until the last token.
            if (error_reg == etsc_pkg::STATUS_OK) begin
                status_now = tok_status;
                if (!cnt_fail) begin
                    paren_next   = paren_upd;
                    bracket_next = bracket_upd;
                    saved_next   = saved_upd;
                end
                if (tok_status == etsc_pkg::STATUS_OK) begin
                    opnd_ok_next = q_data.opnd_after;
                    oper_ok_next = q_data.oper_after;
                end
            end
            if (q_data.last && status_now == etsc_pkg::STATUS_OK
                && (paren_next != '0 || bracket_next != '0)) begin
                status_now = etsc_pkg::STATUS_UNMATCHED;
            end
            error_next = status_now;

            m_valid_next         = 1'b1;
            m_data_next.depth    = depth_sum[etsc_pkg::DEPTH_W-1:0];
            m_data_next.status   = status_now;
            m_data_next.done_res = q_data.last;

            if (q_data.last) begin
                paren_next   = '0;
                bracket_next = '0;
                saved_next   = '0;
                error_next   = etsc_pkg::STATUS_OK;
                opnd_ok_next = 1'b1;
                oper_ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paren_reg   <= '0;
            bracket_reg <= '0;
            saved_reg   <= '0;
            error_reg   <= etsc_pkg::STATUS_OK;
            opnd_ok_reg <= 1'b1;
            oper_ok_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            paren_reg   <= paren_next;
            bracket_reg <= bracket_next;
            saved_reg   <= saved_next;
            error_reg   <= error_next;
            opnd_ok_reg <= opnd_ok_next;
            oper_ok_reg <= oper_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

### sv/etsc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the expression token syntax checker, and its bind.
// Depends on etsc_pkg and expression_token_syntax_checker.
module etsc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input etsc_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input etsc_pkg::out_item_t  m_data
);

    logic                             s_take;
    logic                             m_take;
    logic [etsc_pkg::QCNT_W+1:0]      pending_reg, pending_next;
    etsc_pkg::status_t                sticky_reg, sticky_next;
    logic                             first_reg, first_next;

    assign s_take = s_valid && s_ready;
    assign m_take = m_valid && m_ready;

    // Tokens accepted whose results have not yet been taken, the held error of
    // the expression in progress, and whether the next result opens an expression.
    always_comb begin
        pending_next = pending_reg;
        if (s_take && !m_take) begin
            pending_next = pending_reg + (etsc_pkg::QCNT_W + 2)'(1);
        end else if (m_take && !s_take) begin
            pending_next = pending_reg - (etsc_pkg::QCNT_W + 2)'(1);
        end
        sticky_next = sticky_reg;
        first_next  = first_reg;
        if (m_take) begin
            sticky_next = m_data.done_res ? etsc_pkg::STATUS_OK : m_data.status;
            first_next  = m_data.done_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            sticky_reg  <= etsc_pkg::STATUS_OK;
            first_reg   <= 1'b1;
        end else begin
            pending_reg <= pending_next;
            sticky_reg  <= sticky_next;
            first_reg   <= first_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take |-> pending_reg != '0)
        else $error("result without an accepted token");

    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take && sticky_reg != etsc_pkg::STATUS_OK |-> m_data.status == sticky_reg)
        else $error("held error changed before the last token");

    a_fresh_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take && first_reg |-> m_data.depth == '0)
        else $error("expression did not start at depth zero");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind expression_token_syntax_checker etsc_checker u_etsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
